// ===== design/crm_pkg.sv =====
// ============================================================================
// crm_pkg
// Shared types, character constants and prefix tables for the column
// reference matcher.
// ============================================================================
package crm_pkg;

    localparam int MAX_COLUMN_DEF  = 64;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int DEPTH_W         = 16;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_K      = 8'h6B;
    localparam logic [7:0] CH_V      = 8'h76;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_KEYS     = 2'd1,
        KIND_VALUES   = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_BODY,
        ST_DONE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan_start;
        logic prefix_step;
        logic body_step;
        logic out_nomatch;
        logic out_overflow;
        logic out_empty;
        logic burst_start;
        logic rd_issue;
        logic out_byte;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_ok;
        logic prefix_ok;
        logic prefix_last;
        logic close_final;
        logic fin_overflow;
        logic fin_empty;
        logic burst_last;
        logic out_free;
    } status_t;

    // A preceding character that makes the reference part of a longer name.
    function automatic logic rejected_char(input logic [7:0] c);
        logic r;
        r = (c == CH_QUOTE) || (c == CH_CARET) || (c == CH_DOLLAR) ||
            (c == CH_AMP) || (c == CH_PCT) || (c == CH_DOT) ||
            ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h30) && (c <= 8'h39));
        return r;
    endfunction

    function automatic logic [2:0] prefix_len(input logic is_keys);
        return is_keys ? 3'd5 : 3'd7;
    endfunction

    // Expected character of "keys(" or "values(" at a position.
    function automatic logic [7:0] prefix_char(input logic is_keys, input logic [2:0] pos);
        logic [7:0] c;
        if (is_keys) begin
            case (pos)
                3'd0:    c = 8'h6B;
                3'd1:    c = 8'h65;
                3'd2:    c = 8'h79;
                3'd3:    c = 8'h73;
                3'd4:    c = CH_OPEN;
                default: c = 8'h00;
            endcase
        end else begin
            case (pos)
                3'd0:    c = 8'h76;
                3'd1:    c = 8'h61;
                3'd2:    c = 8'h6C;
                3'd3:    c = 8'h75;
                3'd4:    c = 8'h65;
                3'd5:    c = 8'h73;
                3'd6:    c = CH_OPEN;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== design/crm_ctrl.sv =====
// ============================================================================
// crm_ctrl
// Scan sequencer: tracks the scan phase and the column burst, and issues
// datapath commands.
// ============================================================================
module crm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             first_byte,
    input  logic             end_of_text,
    input  crm_pkg::status_t status,
    output crm_pkg::cmd_t    cmd,
    output logic             in_stall
);

    crm_pkg::state_t state_reg;
    crm_pkg::state_t state_next;
    logic            accepting;
    logic            take;

    assign accepting = (state_reg == crm_pkg::ST_IDLE) || (state_reg == crm_pkg::ST_PREFIX) ||
                       (state_reg == crm_pkg::ST_BODY) || (state_reg == crm_pkg::ST_DONE);
    assign in_stall  = !accepting || !status.out_free;
    assign take      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crm_pkg::ST_IDLE, crm_pkg::ST_DONE, crm_pkg::ST_PREFIX, crm_pkg::ST_BODY:
            begin
                if (take)
                begin
                    if (first_byte)
                    begin
                        state_next = (!end_of_text && status.first_ok) ?
                                     crm_pkg::ST_PREFIX : crm_pkg::ST_DONE;
                    end
                    else if (state_reg == crm_pkg::ST_PREFIX)
                    begin
                        if (end_of_text || !status.prefix_ok)
                            state_next = crm_pkg::ST_DONE;
                        else if (status.prefix_last)
                            state_next = crm_pkg::ST_BODY;
                    end
                    else if (state_reg == crm_pkg::ST_BODY)
                    begin
                        if (end_of_text)
                            state_next = crm_pkg::ST_DONE;
                        else if (status.close_final)
                            state_next = (status.fin_overflow || status.fin_empty) ?
                                         crm_pkg::ST_DONE : crm_pkg::ST_FETCH;
                    end
                end
            end
            crm_pkg::ST_FETCH:
            begin
                state_next = crm_pkg::ST_LOAD;
            end
            crm_pkg::ST_LOAD:
            begin
                if (status.out_free)
                    state_next = status.burst_last ? crm_pkg::ST_DONE : crm_pkg::ST_FETCH;
            end
            default:
            begin
                state_next = crm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            crm_pkg::ST_IDLE, crm_pkg::ST_DONE, crm_pkg::ST_PREFIX, crm_pkg::ST_BODY:
            begin
                if (take)
                begin
                    if (first_byte)
                    begin
                        cmd.scan_start  = 1'b1;
                        cmd.out_nomatch = end_of_text || !status.first_ok;
                    end
                    else if (state_reg == crm_pkg::ST_PREFIX)
                    begin
                        if (end_of_text || !status.prefix_ok)
                            cmd.out_nomatch = 1'b1;
                        else
                            cmd.prefix_step = 1'b1;
                    end
                    else if (state_reg == crm_pkg::ST_BODY)
                    begin
                        if (end_of_text)
                        begin
                            cmd.out_nomatch = 1'b1;
                        end
                        else
                        begin
                            cmd.body_step = 1'b1;
                            if (status.close_final)
                            begin
                                if (status.fin_overflow)
                                    cmd.out_overflow = 1'b1;
                                else if (status.fin_empty)
                                    cmd.out_empty = 1'b1;
                                else
                                    cmd.burst_start = 1'b1;
                            end
                        end
                    end
                end
            end
            crm_pkg::ST_FETCH:
            begin
                cmd.rd_issue = 1'b1;
            end
            crm_pkg::ST_LOAD:
            begin
                cmd.out_byte = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/crm_datapath.sv =====
// ============================================================================
// crm_datapath
// Scan counters, raw column buffer, strip and overflow checks, and the
// output word register.
// ============================================================================
module crm_datapath #(
    parameter int MAX_COLUMN  = crm_pkg::MAX_COLUMN_DEF,
    parameter int LENGTH_BITS = crm_pkg::LENGTH_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  crm_pkg::cmd_t    cmd,
    input  logic [7:0]       text_byte,
    input  logic [7:0]       preceding_char,
    input  logic             out_stall,
    output crm_pkg::status_t status,
    output logic             out_valid,
    output logic [1:0]       match_kind,
    output logic [7:0]       column_byte,
    output logic             byte_valid,
    output logic [15:0]      expression_length,
    output logic             last_result
);

    localparam int STORE = MAX_COLUMN + 2;
    localparam int CW    = $clog2(STORE + 1);
    localparam int AW    = $clog2(STORE);

    logic                          keys_reg;
    logic [2:0]                    pos_reg;
    logic [crm_pkg::DEPTH_W-1:0]   depth_reg;
    logic [CW-1:0]                 count_reg;
    logic                          too_long_reg;
    logic [LENGTH_BITS-1:0]        len_reg;
    logic [7:0]                    head_reg;
    logic [7:0]                    tail_reg;
    logic                          strip_reg;
    logic [CW-1:0]                 col_len_reg;
    logic [CW-1:0]                 idx_reg;
    logic [7:0]                    mem_q_reg;
    logic                          out_valid_reg;
    crm_pkg::kind_t                kind_reg;
    logic [7:0]                    byte_reg;
    logic                          bvalid_reg;
    logic [15:0]                   elen_reg;
    logic                          last_reg;

    logic [7:0]                    store_mem [STORE];

    logic [LENGTH_BITS-1:0]        len_sat;
    logic [15:0]                   elen_now;
    logic [15:0]                   elen_held;
    logic                          is_open;
    logic                          is_close;
    logic                          has_n;
    logic                          strip_s;
    logic [CW-1:0]                 end_e;
    logic [CW-1:0]                 diff;
    logic [CW-1:0]                 rd_sum;
    logic [CW-1:0]                 idx_inc;
    logic                          store_en;
    crm_pkg::kind_t                match_k;

    assign is_open  = (text_byte == crm_pkg::CH_OPEN);
    assign is_close = (text_byte == crm_pkg::CH_CLOSE);
    assign len_sat  = (len_reg == '1) ? len_reg : len_reg + 1'b1;
    assign elen_now  = ({{(33 - LENGTH_BITS){1'b0}}, len_sat} > 33'd65535) ?
                       16'hFFFF : 16'(len_sat);
    assign elen_held = ({{(33 - LENGTH_BITS){1'b0}}, len_reg} > 33'd65535) ?
                       16'hFFFF : 16'(len_reg);
    assign match_k  = keys_reg ? crm_pkg::KIND_KEYS : crm_pkg::KIND_VALUES;

    // Strip one leading and one trailing quote from the buffered text.
    assign has_n   = (count_reg != '0);
    assign strip_s = has_n && (head_reg == crm_pkg::CH_QUOTE);
    assign end_e   = count_reg - CW'(has_n && (tail_reg == crm_pkg::CH_QUOTE));
    assign diff    = end_e - CW'(strip_s);
    assign rd_sum  = idx_reg + CW'(strip_reg);
    assign idx_inc = idx_reg + 1'b1;
    assign store_en = cmd.body_step && !(is_close && (depth_reg <= 16'd1)) &&
                      (count_reg < CW'(STORE));

    always_comb
    begin
        status.first_ok     = !crm_pkg::rejected_char(preceding_char) &&
                              ((text_byte == crm_pkg::CH_K) || (text_byte == crm_pkg::CH_V));
        status.prefix_ok    = (pos_reg < crm_pkg::prefix_len(keys_reg)) &&
                              (text_byte == crm_pkg::prefix_char(keys_reg, pos_reg));
        status.prefix_last  = ((pos_reg + 3'd1) == crm_pkg::prefix_len(keys_reg));
        status.close_final  = is_close && (depth_reg <= 16'd1);
        status.fin_overflow = too_long_reg || (end_e < CW'(strip_s)) ||
                              (diff > CW'(MAX_COLUMN));
        status.fin_empty    = (diff == '0);
        status.burst_last   = (idx_inc == col_len_reg);
        status.out_free     = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg      <= 1'b0;
            pos_reg       <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            too_long_reg  <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                keys_reg     <= (text_byte == crm_pkg::CH_K);
                pos_reg      <= 3'd1;
                depth_reg    <= '0;
                count_reg    <= '0;
                too_long_reg <= 1'b0;
                len_reg      <= LENGTH_BITS'(1);
            end
            if (cmd.prefix_step)
            begin
                len_reg <= len_sat;
                pos_reg <= pos_reg + 3'd1;
                if (status.prefix_last)
                    depth_reg <= 16'd1;
            end
            if (cmd.body_step)
            begin
                len_reg <= len_sat;
                if (is_open && (depth_reg != '1))
                    depth_reg <= depth_reg + 1'b1;
                else if (is_close && (depth_reg != '0))
                    depth_reg <= depth_reg - 1'b1;
                if (store_en)
                    count_reg <= count_reg + 1'b1;
                else if (!status.close_final)
                    too_long_reg <= 1'b1;
            end
            if (cmd.burst_start)
                idx_reg <= '0;
            else if (cmd.out_byte)
                idx_reg <= idx_inc;

            if (cmd.out_nomatch || cmd.out_overflow || cmd.out_empty || cmd.out_byte)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Raw column buffer with registered read, plus the head and tail bytes.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[count_reg[AW-1:0]] <= text_byte;
            tail_reg <= text_byte;
            if (count_reg == '0)
                head_reg <= text_byte;
        end
        if (cmd.rd_issue)
            mem_q_reg <= store_mem[rd_sum[AW-1:0]];
        if (cmd.burst_start)
        begin
            strip_reg   <= strip_s;
            col_len_reg <= diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_nomatch || cmd.out_overflow)
        begin
            kind_reg   <= cmd.out_overflow ? crm_pkg::KIND_OVERFLOW : crm_pkg::KIND_NONE;
            byte_reg   <= 8'h00;
            bvalid_reg <= 1'b0;
            elen_reg   <= 16'h0000;
            last_reg   <= 1'b1;
        end
        else if (cmd.out_empty)
        begin
            kind_reg   <= match_k;
            byte_reg   <= 8'h00;
            bvalid_reg <= 1'b0;
            elen_reg   <= elen_now;
            last_reg   <= 1'b1;
        end
        else if (cmd.out_byte)
        begin
            kind_reg   <= match_k;
            byte_reg   <= mem_q_reg;
            bvalid_reg <= 1'b1;
            elen_reg   <= elen_held;
            last_reg   <= status.burst_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign match_kind        = kind_reg;
    assign column_byte       = byte_reg;
    assign byte_valid        = bvalid_reg;
    assign expression_length = elen_reg;
    assign last_result       = last_reg;

endmodule

// ===== design/column_reference_matcher.sv =====
// ============================================================================
// column_reference_matcher
// Detects a keys( or values( column reference at the start of a text and
// returns the column name, one byte per output word.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall) carries one text byte per word,
// with first_byte marking a new scan and preceding_char giving the
// character in front of it. end_of_text marks the terminating NUL.
// The output channel (out_valid, out_stall) carries result words; each scan
// ends in exactly one word with last_result set.
// Timing: a single no-match, overflow or empty-column word appears in the
// cycle after the byte that causes it. After the closing parenthesis, each
// column byte passes through the FETCH state, one registered read of the
// column buffer, and the LOAD state, which waits for a free output word.
// Throughput: one text byte per cycle outside a burst. Input is held off for
// the whole burst and whenever the output word register is full and stalled.
// Reset clears the scan phase, the counters and the output valid; the column
// buffer is not cleared, and only entries written during the current scan are
// ever read. While out_stall is high the current output word holds.
// ============================================================================
module column_reference_matcher #(
    parameter int MAX_COLUMN  = crm_pkg::MAX_COLUMN_DEF,
    parameter int LENGTH_BITS = crm_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        first_byte,
    input  logic [7:0]  preceding_char,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  match_kind,
    output logic [7:0]  column_byte,
    output logic        byte_valid,
    output logic [15:0] expression_length,
    output logic        last_result
);

    crm_pkg::cmd_t    cmd;
    crm_pkg::status_t status;

    // The sequencer owns the scan phase; the datapath owns all counters,
    // the buffer and the output word.
    crm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .first_byte  (first_byte),
        .end_of_text (end_of_text),
        .status      (status),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    crm_datapath #(
        .MAX_COLUMN  (MAX_COLUMN),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .text_byte         (text_byte),
        .preceding_char    (preceding_char),
        .out_stall         (out_stall),
        .status            (status),
        .out_valid         (out_valid),
        .match_kind        (match_kind),
        .column_byte       (column_byte),
        .byte_valid        (byte_valid),
        .expression_length (expression_length),
        .last_result       (last_result)
    );

    // A full, stalled output word must hold off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output word is stalled");

    // Column bytes only come with a keys or values match.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |->
            (match_kind == crm_pkg::KIND_KEYS) || (match_kind == crm_pkg::KIND_VALUES))
        else $error("column byte with a non-match kind");

    // A no-match or overflow word is always a lone final word with no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((match_kind == crm_pkg::KIND_NONE) ||
                      (match_kind == crm_pkg::KIND_OVERFLOW)) |->
            last_result && !byte_valid && (expression_length == 16'h0000))
        else $error("malformed no-match word");

    // Starting a column burst holds off the input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.burst_start |=> in_stall)
        else $error("input accepted during a column burst");

endmodule
